@@ sv/fpmf_pkg.sv @@
// Package with the beat types and fixed codes of the first pattern match finder.
package fpmf_pkg;

    // Width of the reported position field.
    localparam int unsigned POS_W = 17;

    // Codes of the func field.
    localparam logic FUNC_PATTERN = 1'b0;
    localparam logic FUNC_TEXT    = 1'b1;

    typedef struct packed {
        logic               func;
        logic signed [31:0] value;
        logic               last;
    } t_in_beat;

    typedef struct packed {
        logic             found;
        logic [POS_W-1:0] position;
    } t_out_beat;

endpackage

@@ sv/first_pattern_match_finder_unit.sv @@
// Top level of the first pattern match finder: finds the first full occurrence of a pattern.
//
// Usage: the input channel carries beats of {func, value, last}. Beats with func set to
// pattern load the pattern word by word, and the beat flagged last fixes its length. Words
// beyond PATTERN_MAX are dropped. Beats with func set to text then stream the text, and the
// text beat flagged last produces exactly one result beat {found, position}: the start index
// of the first full match, or the number of text words (saturated at TEXT_MAX) when there is
// none. An empty pattern matches at index 0. A pattern beat arriving during a text abandons
// that text without a result. The pattern is kept from one text to the next.
// Throughput is one beat per cycle while o_in_stall is low: every stored pattern word is
// compared with the incoming text word at once in a single row of comparators, so there is
// no iteration per beat. An accepted final text beat sits in the input register while the
// comparator row works, and the result register loads from it once the beat may proceed.
// Reset (synchronous, active low) empties both registers, forgets the pattern length and
// clears the search state. The stored pattern words themselves are not cleared.
// When the receiver stalls, the result beat holds in the output register. A further final
// text beat then waits in the input register, which raises o_in_stall; pattern and non-final
// text beats keep flowing past a stalled result.
module first_pattern_match_finder_unit #(
    parameter int unsigned PATTERN_MAX = 16,
    parameter int unsigned TEXT_MAX    = 65536
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  fpmf_pkg::t_in_beat  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output fpmf_pkg::t_out_beat o_out_data
);

    // Width of the load index and the pattern length, which both reach PATTERN_MAX.
    localparam int unsigned LW = $clog2(PATTERN_MAX + 1);
    // Width of the text index, which saturates at TEXT_MAX.
    localparam int unsigned TW = $clog2(TEXT_MAX + 1);
    // Working width for the position arithmetic: never narrower than the output field.
    localparam int unsigned XW = (TW > fpmf_pkg::POS_W) ? TW : fpmf_pkg::POS_W;

    // Input register.
    logic               r_in_valid;
    fpmf_pkg::t_in_beat r_in;

    // Pattern and search state.
    logic signed [31:0]         r_store [PATTERN_MAX];
    logic [LW-1:0]              r_pattern_length;
    logic [LW-1:0]              r_load_index;
    logic [PATTERN_MAX-1:0]     r_partial;
    logic [TW-1:0]              r_text_index;
    logic                       r_match_seen;
    logic [fpmf_pkg::POS_W-1:0] r_match_start;

    // Result register.
    logic                r_out_valid;
    fpmf_pkg::t_out_beat r_out;

    logic                       w_is_pattern;
    logic                       w_is_final_text;
    logic                       w_out_free;
    logic                       w_fire;
    logic [PATTERN_MAX-1:0]     w_eq;
    logic [PATTERN_MAX-1:0]     w_len_mask;
    logic [PATTERN_MAX-1:0]     w_top_bit;
    logic [PATTERN_MAX-1:0]     n_partial;
    logic                       w_full_match;
    logic                       w_load_room;
    logic [LW-1:0]              w_load_next;
    logic [TW-1:0]              w_idx_next;
    logic [XW-1:0]              w_start_ext;
    logic [XW-1:0]              w_count_ext;
    logic                       n_match_seen;
    logic [fpmf_pkg::POS_W-1:0] n_match_start;

    assign w_is_pattern    = (r_in.func == fpmf_pkg::FUNC_PATTERN);
    assign w_is_final_text = (r_in.func == fpmf_pkg::FUNC_TEXT) && r_in.last;

    // A beat in the input register may proceed unless it yields a result that has nowhere
    // to go because the previous result is still held by a stalled receiver.
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_fire     = r_in_valid && (!w_is_final_text || w_out_free);
    assign o_in_stall = r_in_valid && !w_fire;

    // Comparator row: every pattern position against the current text word, each position
    // qualified by the pattern length. The top bit marks position length minus one.
    always_comb begin
        for (int j = 0; j < PATTERN_MAX; j++) begin
            w_eq[j]       = (r_store[j] == r_in.value);
            w_len_mask[j] = (32'(j) < 32'(r_pattern_length));
            w_top_bit[j]  = ((32'(j) + 32'd1) == 32'(r_pattern_length));
        end
    end

    // Bit j of the partial vector means the first j+1 pattern words end at this text word.
    assign n_partial    = ((r_partial << 1) | PATTERN_MAX'(1)) & w_eq & w_len_mask;
    assign w_full_match = |(n_partial & w_top_bit);

    assign w_idx_next  = (r_text_index < TW'(TEXT_MAX)) ? (r_text_index + TW'(1))
                                                        : r_text_index;
    // Start of a match that ends at the current word: index minus (length minus one).
    assign w_start_ext = XW'(r_text_index) - XW'(r_pattern_length) + XW'(1);
    assign w_count_ext = XW'(w_idx_next);

    always_comb begin
        n_match_seen  = r_match_seen;
        n_match_start = r_match_start;
        if (!r_match_seen) begin
            if (r_pattern_length == '0) begin
                n_match_seen  = 1'b1;
                n_match_start = '0;
            end else if (w_full_match) begin
                n_match_seen  = 1'b1;
                n_match_start = w_start_ext[fpmf_pkg::POS_W-1:0];
            end
        end
    end

    assign w_load_room = (r_load_index < LW'(PATTERN_MAX));
    assign w_load_next = w_load_room ? (r_load_index + LW'(1)) : r_load_index;

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // Pattern store: each entry is written only while its position is being loaded.
    for (genvar g = 0; g < PATTERN_MAX; g++) begin : g_store
        always_ff @(posedge i_clk) begin
            if (w_fire && w_is_pattern && (32'(r_load_index) == g)) begin
                r_store[g] <= r_in.value;
            end
        end
    end

    // Pattern length, load index and search state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pattern_length <= '0;
            r_load_index     <= '0;
            r_partial        <= '0;
            r_text_index     <= '0;
            r_match_seen     <= 1'b0;
            r_match_start    <= '0;
        end else if (w_fire) begin
            if (w_is_pattern || r_in.last) begin
                // A pattern beat abandons any text, and a final text beat ends it.
                r_partial     <= '0;
                r_text_index  <= '0;
                r_match_seen  <= 1'b0;
                r_match_start <= '0;
            end else begin
                r_partial     <= n_partial;
                r_text_index  <= w_idx_next;
                r_match_seen  <= n_match_seen;
                r_match_start <= n_match_start;
            end
            if (w_is_pattern) begin
                if (r_in.last) begin
                    r_pattern_length <= w_load_next;
                    r_load_index     <= '0;
                end else begin
                    r_load_index <= w_load_next;
                end
            end
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_is_final_text) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_is_final_text) begin
            r_out.found    <= n_match_seen;
            r_out.position <= n_match_seen ? n_match_start
                                           : w_count_ext[fpmf_pkg::POS_W-1:0];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // A stall towards the sender is only ever caused by a held beat in the input register.
    a_stall_needs_beat : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_valid && w_is_final_text && r_out_valid && i_out_stall))
        else $error("input stalled without a blocked final text beat");

    // A fresh result beat comes only from a final text beat taken by the comparator row.
    a_result_source : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !$past(o_out_valid) && $past(i_rst_n)) |->
            $past(r_in_valid && r_in.func == fpmf_pkg::FUNC_TEXT && r_in.last))
        else $error("result beat without a final text beat");

    // The load index never runs past the store, and the text index saturates.
    a_index_bounds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_load_index <= LW'(PATTERN_MAX)) && (r_text_index <= TW'(TEXT_MAX)))
        else $error("index beyond its bound");

    // Partial matches never extend past the loaded pattern length.
    a_partial_in_length : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_partial & ~w_len_mask) == '0)
        else $error("partial match bit beyond pattern length");

endmodule

@@ tb/sv/tb_first_pattern_match_finder_unit.sv @@
// Self-checking testbench of the first pattern match finder, with its own scoreboard class.
module tb_first_pattern_match_finder_unit;

    localparam int unsigned PATTERN_MAX = 16;
    localparam int unsigned TEXT_MAX    = 65536;
    // Cycles the receiver holds off in one go, so that the block fills and stalls its input.
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned RANDOM_BEATS = 600;

    // The scoreboard keeps its own copy of the search state. Every accepted input beat is
    // folded into that state, and a final text beat leaves one expected result behind.
    class fpmf_scoreboard;
        logic [31:0]                pattern_words [PATTERN_MAX];
        int unsigned                pattern_len;
        int unsigned                load_pos;
        logic [PATTERN_MAX-1:0]     prefix_bits;
        logic [fpmf_pkg::POS_W-1:0] text_pos;
        bit                         seen;
        logic [fpmf_pkg::POS_W-1:0] first_start;
        fpmf_pkg::t_out_beat        awaited [$];
        int unsigned                failures;
        int unsigned                results_checked;

        function new();
            foreach (pattern_words[j]) pattern_words[j] = '0;
            pattern_len     = 0;
            load_pos        = 0;
            failures        = 0;
            results_checked = 0;
            clear_text();
        endfunction

        function void clear_text();
            prefix_bits = '0;
            text_pos    = '0;
            seen        = 1'b0;
            first_start = '0;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function void note_input(fpmf_pkg::t_in_beat b);
            logic [PATTERN_MAX-1:0]     eq;
            logic [fpmf_pkg::POS_W-1:0] idx;
            fpmf_pkg::t_out_beat        res;
            if (b.func == fpmf_pkg::FUNC_PATTERN) begin
                // Any pattern beat drops the text in progress.
                clear_text();
                if (load_pos < PATTERN_MAX) begin
                    pattern_words[load_pos] = b.value;
                    load_pos++;
                end
                if (b.last) begin
                    pattern_len = load_pos;
                    load_pos    = 0;
                end
                return;
            end
            idx = text_pos;
            if (pattern_len == 0) begin
                // An empty pattern matches at the very start.
                if (!seen) begin
                    seen        = 1'b1;
                    first_start = '0;
                end
            end else begin
                eq = '0;
                for (int j = 0; j < int'(pattern_len); j++)
                    eq[j] = (pattern_words[j] == b.value);
                prefix_bits = ((prefix_bits << 1) | PATTERN_MAX'(1)) & eq;
                if (prefix_bits[pattern_len-1] && !seen) begin
                    seen        = 1'b1;
                    first_start = idx - fpmf_pkg::POS_W'(pattern_len - 1);
                end
            end
            if (text_pos < TEXT_MAX)
                text_pos++;
            if (b.last) begin
                res.found    = seen;
                res.position = seen ? first_start : text_pos;
                awaited.insert(awaited.size(), res);
                clear_text();
            end
        endfunction

        function void check_result(fpmf_pkg::t_out_beat r);
            fpmf_pkg::t_out_beat exp_res;
            if (awaited.size() == 0) begin
                $error("result beat with nothing expected: found %0d position %0d",
                       r.found, r.position);
                failures++;
                return;
            end
            exp_res = awaited.pop_front();
            results_checked++;
            if (r.found !== exp_res.found) begin
                $error("found: expected %0d, actual %0d", exp_res.found, r.found);
                failures++;
            end
            if (r.position !== exp_res.position) begin
                $error("position: expected %0d, actual %0d", exp_res.position, r.position);
                failures++;
            end
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n   = 1'b0;
    logic                in_valid  = 1'b0;
    logic                o_in_stall;
    fpmf_pkg::t_in_beat  in_data   = '0;
    logic                o_out_valid;
    logic                out_stall = 1'b0;
    fpmf_pkg::t_out_beat o_out_data;

    fpmf_scoreboard sb = new();

    // Shared between the sender and the receiver: quiet suppresses random idling on both
    // sides, and hold_req asks the receiver to begin its long hold-off.
    bit          quiet    = 1'b0;
    bit          hold_req = 1'b0;
    int unsigned beats_sent    = 0;
    int unsigned pattern_beats = 0;
    logic [31:0] cur_pattern [$];

    first_pattern_match_finder_unit #(
        .PATTERN_MAX(PATTERN_MAX),
        .TEXT_MAX   (TEXT_MAX)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (in_data),
        .o_out_valid(o_out_valid),
        .i_out_stall(out_stall),
        .o_out_data (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Offers one beat and returns at the edge where it is taken. Valid is left high after
    // the beat so that back-to-back beats need no second assignment in the same step; an
    // idle gap, when one is drawn, lowers it first.
    task automatic send_beat(input logic func, input logic [31:0] value, input logic last);
        fpmf_pkg::t_in_beat b;
        int unsigned        gap;
        b.func  = func;
        b.value = value;
        b.last  = last;
        if (!quiet && $urandom_range(99) < 17) begin
            in_valid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data  <= b;
        // o_in_stall read just after the edge still holds the value the edge saw.
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(b);
        beats_sent++;
        if (func == fpmf_pkg::FUNC_PATTERN)
            pattern_beats++;
    endtask

    // One random session: usually a fresh pattern drawn from a tiny alphabet, so that it
    // repeats itself and overlapping partial matches occur, then a few texts over the same
    // alphabet, some of them with the pattern planted whole or cut off at the end. A few
    // sessions are pure noise, leave a load open, or leave a text without its final beat.
    task automatic run_session();
        logic [31:0] alphabet [3];
        logic [31:0] w;
        int          plen;
        int          ntexts;
        int          tlen;
        int          plant_at;
        bit          reload;
        bit          close_load;
        if ($urandom_range(99) < 10) begin
            send_beat(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)));
            return;
        end
        reload = (cur_pattern.size() == 0) || ($urandom_range(99) < 70);
        for (int a = 0; a < 3; a++) begin
            if (reload)
                alphabet[a] = $urandom;
            else
                alphabet[a] = cur_pattern[$urandom_range(cur_pattern.size() - 1)];
        end
        if (reload) begin
            plen = ($urandom_range(99) < 90) ? $urandom_range(1, 6)
                                             : $urandom_range(7, PATTERN_MAX + 4);
            close_load = ($urandom_range(99) >= 5);
            cur_pattern.delete();
            for (int p = 0; p < plen; p++) begin
                w = alphabet[$urandom_range(2)];
                if (p < PATTERN_MAX)
                    cur_pattern.insert(cur_pattern.size(), w);
                send_beat(fpmf_pkg::FUNC_PATTERN, w, close_load && (p == plen - 1));
            end
        end
        ntexts = $urandom_range(1, 3);
        repeat (ntexts) begin
            tlen     = $urandom_range(1, 24);
            plant_at = ($urandom_range(99) < 40) ? $urandom_range(0, tlen - 1) : tlen;
            for (int t = 0; t < tlen; t++) begin
                if (t >= plant_at && t - plant_at < cur_pattern.size())
                    w = cur_pattern[t - plant_at];
                else if ($urandom_range(99) < 75)
                    w = alphabet[$urandom_range(2)];
                else
                    w = $urandom;
                send_beat(fpmf_pkg::FUNC_TEXT, w,
                          (t == tlen - 1) && ($urandom_range(99) >= 6));
            end
        end
    endtask

    // Receiver: takes result beats, stalls at random, and once per run holds off for a
    // long stretch counted here, while the sender keeps offering final text beats.
    initial begin : receiver
        int unsigned hold_cnt;
        hold_cnt = 0;
        wait (i_rst_n);
        forever begin
            @(posedge i_clk);
            if (o_out_valid && !out_stall)
                sb.check_result(o_out_data);
            if (hold_cnt > 0) begin
                hold_cnt--;
                out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_cnt  = HOLD_CYCLES;
                out_stall <= 1'b1;
            end else begin
                out_stall <= !quiet && ($urandom_range(99) < 17);
            end
        end
    end

    initial begin : sender
        int unsigned directed_beats;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Before any pattern is loaded the pattern is empty and matches at index 0.
        send_beat(fpmf_pkg::FUNC_TEXT, 32'h8000_0000, 1'b0);
        send_beat(fpmf_pkg::FUNC_TEXT, 32'h7fff_ffff, 1'b1);
        // A two-word pattern of the extreme values, found one word into the text.
        send_beat(fpmf_pkg::FUNC_PATTERN, 32'h8000_0000, 1'b0);
        send_beat(fpmf_pkg::FUNC_PATTERN, 32'h7fff_ffff, 1'b1);
        send_beat(fpmf_pkg::FUNC_TEXT, 32'h0000_0000, 1'b0);
        send_beat(fpmf_pkg::FUNC_TEXT, 32'h8000_0000, 1'b0);
        send_beat(fpmf_pkg::FUNC_TEXT, 32'h7fff_ffff, 1'b0);
        send_beat(fpmf_pkg::FUNC_TEXT, 32'h0000_0000, 1'b1);
        // The start of a match cut off by the end of the text does not count.
        send_beat(fpmf_pkg::FUNC_TEXT, 32'hffff_ffff, 1'b0);
        send_beat(fpmf_pkg::FUNC_TEXT, 32'h8000_0000, 1'b1);
        // A pattern beat in the middle of a text abandons it without a result.
        send_beat(fpmf_pkg::FUNC_TEXT, 32'h8000_0000, 1'b0);
        send_beat(fpmf_pkg::FUNC_PATTERN, 32'h0000_0005, 1'b1);
        send_beat(fpmf_pkg::FUNC_TEXT, 32'h0000_0005, 1'b1);
        // A load left open: the old length applies to the partly rewritten store.
        send_beat(fpmf_pkg::FUNC_PATTERN, 32'h0000_0009, 1'b0);
        send_beat(fpmf_pkg::FUNC_TEXT, 32'h0000_0009, 1'b1);
        send_beat(fpmf_pkg::FUNC_TEXT, 32'h0000_0005, 1'b1);
        // Closing the load gives a self-overlapping pattern of two equal words.
        send_beat(fpmf_pkg::FUNC_PATTERN, 32'h0000_0009, 1'b1);
        send_beat(fpmf_pkg::FUNC_TEXT, 32'h0000_0001, 1'b0);
        send_beat(fpmf_pkg::FUNC_TEXT, 32'h0000_0009, 1'b0);
        send_beat(fpmf_pkg::FUNC_TEXT, 32'h0000_0009, 1'b1);
        directed_beats = beats_sent;

        // Random sessions, with a stretch in the middle where neither side idles.
        while (beats_sent < directed_beats + RANDOM_BEATS) begin
            quiet = (beats_sent >= directed_beats + 250) && (beats_sent < directed_beats + 400);
            run_session();
        end
        quiet = 1'b0;

        // Back pressure: many short texts while the receiver holds off.
        hold_req = 1'b1;
        for (int n = 0; n < 24; n++)
            send_beat(fpmf_pkg::FUNC_TEXT, $urandom, 1'b1);

        // The last beat has just been taken, so valid drops at once.
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        // Once nothing is pending, wait a little longer for stray results.
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d input beats (%0d pattern, %0d text) and %0d result beats,",
                 beats_sent, pattern_beats, beats_sent - pattern_beats, sb.results_checked);
        $display("including a %0d-cycle receiver hold-off that backed up the input.",
                 HOLD_CYCLES);
        if (sb.failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // The slowest correct run stays below a hundred thousand time units; this allows
    // several times that before giving up.
    initial begin : watchdog
        #1_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

@@ sim.f @@
sv/fpmf_pkg.sv
sv/first_pattern_match_finder_unit.sv
tb/sv/tb_first_pattern_match_finder_unit.sv
